[rtl/ssrs_pkg.sv]
// Package for the seven-segment refresh scheduler.
// Holds payload structs, action, packet and command codes, and the segment encoder.
// No dependencies.
package ssrs_pkg;

    // Input item fields
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] number_value;
    } t_in_item;

    // Result item fields
    typedef struct packed {
        logic       send_valid;
        logic [7:0] command_byte;
        logic [7:0] data_byte;
        logic       busy_res;
    } t_out_item;

    // Action codes
    localparam logic [1:0] ACT_SHOW    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_DONE    = 2'd2;
    localparam logic [1:0] ACT_MARK    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BRIGHT  = 2'd0;
    localparam logic [1:0] CFG_MODE    = 2'd1;
    localparam logic [1:0] CFG_AWAKE   = 2'd2;
    localparam logic [1:0] CFG_DISPLAY = 2'd3;

    // In-flight packet codes
    localparam logic [2:0] PKT_NONE    = 3'd0;
    localparam logic [2:0] PKT_HUND    = 3'd1;
    localparam logic [2:0] PKT_TENS    = 3'd2;
    localparam logic [2:0] PKT_UNITS   = 3'd3;
    localparam logic [2:0] PKT_CTRL    = 3'd4;

    // Pending mark bit positions
    localparam int MARK_HUND  = 0;
    localparam int MARK_TENS  = 1;
    localparam int MARK_UNITS = 2;
    localparam int MARK_CTRL  = 3;

    // Bus command bytes
    localparam logic [7:0] CMD_HUNDREDS = 8'h68;
    localparam logic [7:0] CMD_TENS     = 8'h6A;
    localparam logic [7:0] CMD_UNITS    = 8'h6C;
    localparam logic [7:0] CMD_CONTROL  = 8'h48;

    localparam logic [9:0] MAX_SHOWN    = 10'd999;
    localparam logic [7:0] DEC_POINT    = 8'h80;

    // Segment pattern of one decimal digit (bit 0 = A ... bit 6 = G)
    function automatic logic [7:0] seg_encode(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

[rtl/seven_segment_refresh_scheduler_core.sv]
// Top level of the seven-segment refresh scheduler.
// Input register, single-pass update logic and result register.
// Depends on ssrs_pkg.
//
// The input register captures each item; the result register loads from it once the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; set by the single update pass on the state registers.
// Reset: i_rst_n synchronous active low; config to defaults, patterns zero,
// control pending, idle with nothing in flight. No clearing pass.
module seven_segment_refresh_scheduler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ssrs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ssrs_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import ssrs_pkg::*;

    // Configuration registers
    logic [2:0] r_bright;
    logic       r_mode;
    logic       r_awake;
    logic       r_display;

    // Scheduler state
    logic [7:0] r_pat [3];
    logic [7:0] n_pat [3];
    logic [3:0] r_pend, n_pend;
    logic       r_busy, n_busy;
    logic [2:0] r_inflight, n_inflight;

    // Pipeline registers
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item n_out;

    logic       advance;
    logic       process;
    logic [9:0] num_sat;
    logic [3:0] hund, tens, units;
    logic [9:0] hund_base;
    logic [6:0] rem_h;
    logic [6:0] tens_base;
    logic [7:0] pat_new [3];
    logic [7:0] ctrl_byte;

    assign o_cfg_ready = 1'b1;
    assign advance     = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign process     = r_in_valid && advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright  <= 3'd6;
            r_mode    <= 1'b0;
            r_awake   <= 1'b1;
            r_display <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BRIGHT:  r_bright  <= i_cfg_data[2:0];
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_AWAKE:   r_awake   <= i_cfg_data[0];
                CFG_DISPLAY: r_display <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign ctrl_byte = {1'b0, r_bright, 1'b0, r_mode, r_awake, r_display};

    // Saturate and split into decimal digits by threshold counting
    always_comb begin
        num_sat = (r_in_data.number_value > 16'(MAX_SHOWN)) ? MAX_SHOWN
                                                            : r_in_data.number_value[9:0];
        hund = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (num_sat >= 10'(k * 100)) hund = 4'(k);
        end
        hund_base = 10'd0;
        for (int k = 1; k <= 9; k++) begin
            if (hund == 4'(k)) hund_base = 10'(k * 100);
        end
        rem_h = 7'(num_sat - hund_base);
        tens = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem_h >= 7'(k * 10)) tens = 4'(k);
        end
        tens_base = 7'd0;
        for (int k = 1; k <= 9; k++) begin
            if (tens == 4'(k)) tens_base = 7'(k * 10);
        end
        units = 4'(rem_h - tens_base);
        pat_new[0] = seg_encode(hund);
        pat_new[1] = seg_encode(tens) | DEC_POINT;
        pat_new[2] = seg_encode(units);
    end

    // Single-pass state update and result
    always_comb begin
        n_pat      = r_pat;
        n_pend     = r_pend;
        n_busy     = r_busy;
        n_inflight = r_inflight;
        n_out      = '0;
        unique case (r_in_data.action)
            ACT_SHOW: begin
                for (int d = 0; d < 3; d++) begin
                    if (pat_new[d] != r_pat[d]) begin
                        n_pat[d]  = pat_new[d];
                        n_pend[d] = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                if (!r_busy) begin
                    priority if (r_pend[MARK_HUND]) begin
                        n_out.send_valid   = 1'b1;
                        n_out.command_byte = CMD_HUNDREDS;
                        n_out.data_byte    = r_pat[0];
                        n_inflight         = PKT_HUND;
                    end else if (r_pend[MARK_TENS]) begin
                        n_out.send_valid   = 1'b1;
                        n_out.command_byte = CMD_TENS;
                        n_out.data_byte    = r_pat[1];
                        n_inflight         = PKT_TENS;
                    end else if (r_pend[MARK_UNITS]) begin
                        n_out.send_valid   = 1'b1;
                        n_out.command_byte = CMD_UNITS;
                        n_out.data_byte    = r_pat[2];
                        n_inflight         = PKT_UNITS;
                    end else if (r_pend[MARK_CTRL]) begin
                        n_out.send_valid   = 1'b1;
                        n_out.command_byte = CMD_CONTROL;
                        n_out.data_byte    = ctrl_byte;
                        n_inflight         = PKT_CTRL;
                    end else begin
                        // nothing pending: no packet, stay idle
                        n_out.send_valid   = 1'b0;
                    end
                    n_busy = n_out.send_valid;
                end
            end
            ACT_DONE: begin
                if (r_busy) begin
                    unique case (r_inflight)
                        PKT_HUND:  n_pend[MARK_HUND]  = 1'b0;
                        PKT_TENS:  n_pend[MARK_TENS]  = 1'b0;
                        PKT_UNITS: n_pend[MARK_UNITS] = 1'b0;
                        PKT_CTRL:  n_pend[MARK_CTRL]  = 1'b0;
                        default:   ;
                    endcase
                    n_busy     = 1'b0;
                    n_inflight = PKT_NONE;
                end
            end
            ACT_MARK: n_pend[MARK_CTRL] = 1'b1;
            default:  ;
        endcase
        n_out.busy_res = n_busy;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pat       <= '{default: 8'h00};
            r_pend      <= 4'b1000;
            r_busy      <= 1'b0;
            r_inflight  <= PKT_NONE;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (process) begin
                r_out_valid <= 1'b1;
                r_pat       <= n_pat;
                r_pend      <= n_pend;
                r_busy      <= n_busy;
                r_inflight  <= n_inflight;
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
        if (process) begin
            r_out_data <= n_out;
        end
    end

`ifndef SYNTHESIS
    // Busy flag and in-flight code agree
    a_busy_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_inflight != PKT_NONE))
        else $error("busy flag and in-flight packet disagree");

    // A started transfer leaves the block busy
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.send_valid) |-> r_out_data.busy_res)
        else $error("packet sent without busy");

    // Idle results carry zero bytes
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.send_valid) |->
            (r_out_data.command_byte == 8'h00 && r_out_data.data_byte == 8'h00))
        else $error("nonzero bytes without a send");

    // Busy only rises on a processed refresh tick
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(process && r_in_data.action == ACT_TICK))
        else $error("busy rose without a refresh tick");
`endif

endmodule

[tb/seven_segment_refresh_scheduler_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the seven-segment refresh scheduler core.
// Holds a scoreboard class that predicts every result, plus the top module that drives it.
// Depends on ssrs_pkg and seven_segment_refresh_scheduler_core.

import ssrs_pkg::*;

// Tracks digit patterns, pending marks and control settings; queues the result of each item
class refresh_scoreboard;
    bit [7:0]  seg_pat [10];
    bit [7:0]  digit_pat [3];
    bit [3:0]  pending;
    bit        busy;
    bit [2:0]  inflight;
    bit [2:0]  bright;
    bit        mode;
    bit        awake;
    bit        disp;

    t_out_item awaited_results [$];
    int        errors;
    int        items;
    int        effective;
    int        results;
    int        sends;
    int        reg_writes;

    function new();
        seg_pat   = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
        digit_pat = '{8'h00, 8'h00, 8'h00};
        pending   = 4'b0000;
        pending[MARK_CTRL] = 1'b1;
        busy      = 1'b0;
        inflight  = PKT_NONE;
        bright    = 3'd6;
        mode      = 1'b0;
        awake     = 1'b1;
        disp      = 1'b1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
        reg_writes++;
        case (idx)
            CFG_BRIGHT:  bright = val[2:0];
            CFG_MODE:    mode   = val[0];
            CFG_AWAKE:   awake  = val[0];
            CFG_DISPLAY: disp   = val[0];
            default: ;
        endcase
    endfunction

    // Prediction for one accepted input transfer
    function void accept_item(t_in_item it);
        t_out_item   r;
        int unsigned n;
        bit [7:0]    pat [3];
        bit          found;
        r = '0;
        found = 1'b0;
        items++;
        case (it.action)
            ACT_SHOW: begin
                n = it.number_value;
                if (n > MAX_SHOWN)
                    n = MAX_SHOWN;
                pat[0] = seg_pat[n / 100];
                pat[1] = seg_pat[(n / 10) % 10] | DEC_POINT;
                pat[2] = seg_pat[n % 10];
                // only changed digits (decimal point included) become pending
                for (int k = 0; k < 3; k++) begin
                    if (pat[k] != digit_pat[k]) begin
                        digit_pat[k] = pat[k];
                        pending[k] = 1'b1;
                    end
                end
                effective++;
            end
            ACT_TICK: begin
                // first pending packet wins: hundreds, tens, units, control
                if (!busy) begin
                    for (int k = 0; k < 4; k++) begin
                        if (!found && pending[k]) begin
                            found = 1'b1;
                            r.send_valid = 1'b1;
                            case (k)
                                MARK_HUND:  r.command_byte = CMD_HUNDREDS;
                                MARK_TENS:  r.command_byte = CMD_TENS;
                                MARK_UNITS: r.command_byte = CMD_UNITS;
                                default:    r.command_byte = CMD_CONTROL;
                            endcase
                            if (k < MARK_CTRL)
                                r.data_byte = digit_pat[k];
                            else
                                r.data_byte = {1'b0, bright, 1'b0, mode, awake, disp};
                            busy = 1'b1;
                            inflight = 3'(k + 1);
                        end
                    end
                end
                if (found) begin
                    sends++;
                    effective++;
                end
            end
            ACT_DONE: begin
                if (busy) begin
                    if (inflight >= PKT_HUND && inflight <= PKT_CTRL)
                        pending[inflight - 1] = 1'b0;
                    busy = 1'b0;
                    inflight = PKT_NONE;
                    effective++;
                end
            end
            ACT_MARK: begin
                pending[MARK_CTRL] = 1'b1;
                effective++;
            end
        endcase
        r.busy_res = busy;
        awaited_results.push_back(r);
    endfunction

    function void report(string what, t_out_item exp_r, t_out_item act_r);
        errors++;
        if (errors <= 10)
            $display({"[%0t] %s: exp send=%0b cmd=%02h data=%02h busy=%0b, ",
                      "got send=%0b cmd=%02h data=%02h busy=%0b"},
                     $realtime, what, exp_r.send_valid, exp_r.command_byte, exp_r.data_byte,
                     exp_r.busy_res, act_r.send_valid, act_r.command_byte, act_r.data_byte,
                     act_r.busy_res);
    endfunction

    // Compare one accepted result transfer with the oldest prediction
    function void check_result(t_out_item act_r);
        t_out_item exp_r;
        results++;
        if (awaited_results.size() == 0) begin
            report("result with none expected", '0, act_r);
        end else begin
            exp_r = awaited_results.pop_front();
            if (act_r.send_valid !== exp_r.send_valid ||
                act_r.command_byte !== exp_r.command_byte ||
                act_r.data_byte !== exp_r.data_byte ||
                act_r.busy_res !== exp_r.busy_res)
                report("result mismatch", exp_r, act_r);
        end
    endfunction
endclass

module seven_segment_refresh_scheduler_core_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_TARGET  = 175;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    refresh_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    logic [15:0] last_value = 16'd0;

    seven_segment_refresh_scheduler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Transfer monitors on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_valid && o_cfg_ready === 1'b1)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_stall === 1'b0)
                sb.accept_item(i_in_data);
            if (o_out_valid === 1'b1 && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // Run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("seven_segment_refresh_scheduler_core_tb: FAIL");
            $finish;
        end
    end

    // Offer one item; returns after the transfer
    task automatic send_item(logic [1:0] act, logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid             <= 1'b1;
        i_in_data.action       <= act;
        i_in_data.number_value <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for all predicted results, then cover the pipeline latency
    task automatic settle();
        while (sb.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four control registers; unused upper data bits are random
    task automatic set_controls(logic [2:0] b, logic m, logic a, logic d);
        write_reg(CFG_BRIGHT,  {5'($urandom_range(31)), b});
        write_reg(CFG_MODE,    {7'($urandom_range(127)), m});
        write_reg(CFG_AWAKE,   {7'($urandom_range(127)), a});
        write_reg(CFG_DISPLAY, {7'($urandom_range(127)), d});
    endtask

    // Mostly show/tick/done traffic with random values, some control marks
    task automatic run_random(int target);
        int          r;
        int          stop_at;
        logic [15:0] v;
        stop_at = sb.effective + target;
        while (sb.effective < stop_at) begin
            r = $urandom_range(99);
            if (r < 35) begin
                r = $urandom_range(99);
                if (r < 60)
                    v = 16'($urandom_range(999));
                else if (r < 85)
                    v = 16'($urandom_range(65535));
                else
                    v = last_value;
                last_value = v;
                send_item(ACT_SHOW, v);
            end else if (r < 65) begin
                send_item(ACT_TICK, 16'($urandom_range(65535)));
            end else if (r < 93) begin
                send_item(ACT_DONE, 16'($urandom_range(65535)));
            end else begin
                send_item(ACT_MARK, 16'($urandom_range(65535)));
            end
        end
        stop_sending();
    endtask

    initial begin
        int sender_pct [4];
        int stall_set  [4];
        sender_pct = '{0, 68, 0, 36};
        stall_set  = '{0, 0, 68, 36};
        sb = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BRIGHT;
        i_cfg_data  = 8'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset controls: busy/idle corner cases and value extremes
        send_item(ACT_TICK, 16'h0000);   // control packet pending from reset
        send_item(ACT_TICK, 16'hFFFF);   // tick while busy
        send_item(ACT_MARK, 16'h1234);   // re-mark the packet in flight
        send_item(ACT_DONE, 16'h0000);   // clears the mark anyway
        send_item(ACT_DONE, 16'hFFFF);   // done while idle
        send_item(ACT_TICK, 16'h0000);   // nothing pending
        send_item(ACT_SHOW, 16'd0);
        send_item(ACT_SHOW, 16'hFFFF);   // saturates
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_SHOW, 16'd1000);   // saturates to the same digits
        send_item(ACT_SHOW, 16'd123);    // changes the digit in flight
        send_item(ACT_DONE, 16'h0000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_DONE, 16'h0000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_DONE, 16'h0000);
        send_item(ACT_SHOW, 16'hAAAA);
        send_item(ACT_SHOW, 16'h5555);
        send_item(ACT_SHOW, 16'd999);
        send_item(ACT_SHOW, 16'd10);
        send_item(ACT_MARK, 16'h0000);
        send_item(ACT_TICK, 16'h0000);
        send_item(ACT_DONE, 16'h0000);
        stop_sending();
        settle();

        // Random phases, each with its own control settings and idling
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_controls(3'd0, 1'b0, 1'b0, 1'b0);
                1: set_controls(3'd7, 1'b1, 1'b1, 1'b1);
                2: set_controls(3'($urandom_range(7)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
                default: set_controls(3'd5, 1'b1, 1'b0, 1'b1);
            endcase
            send_idle_pct = sender_pct[p];
            stall_pct     = stall_set[p];
            // long receiver hold-off while items keep coming: fills the pipeline
            if (p == 0)
                hold_left = 150;
            run_random(PHASE_TARGET);
            settle();
        end

        repeat (6) @(posedge i_clk);
        $display("Covered %0d items (%0d effective), %0d results, %0d packets sent,",
                 sb.items, sb.effective, sb.results, sb.sends);
        $display("%0d register writes over four idling phases; %0d mismatches.",
                 sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("seven_segment_refresh_scheduler_core_tb: PASS");
        else
            $display("seven_segment_refresh_scheduler_core_tb: FAIL");
        $finish;
    end

endmodule
